FILE: design/lkx_pkg.sv
// ----------------------------------------------------------------------------
// lkx_pkg: shared types and constants of the lcg keystream xor cipher
// Field widths, register indexes, engine phases and the structs that pass
// between the top level and the word engine.
// ----------------------------------------------------------------------------
package lkx_pkg;

  // field widths
  localparam int unsigned LKX_MSG_W      = 8;
  localparam int unsigned LKX_MUL_W      = 32;
  localparam int unsigned LKX_WORD_W     = 31;
  localparam int unsigned LKX_PROD_W     = 64;
  localparam int unsigned LKX_CFG_IDX_W  = 8;
  localparam int unsigned LKX_CFG_DATA_W = 32;

  // register indexes
  localparam logic [LKX_CFG_IDX_W-1:0] LKX_REG_MULT = 8'd0;
  localparam logic [LKX_CFG_IDX_W-1:0] LKX_REG_INCR = 8'd1;
  localparam logic [LKX_CFG_IDX_W-1:0] LKX_REG_MODU = 8'd2;
  localparam logic [LKX_CFG_IDX_W-1:0] LKX_REG_SEED = 8'd3;

  // register reset values
  localparam logic [LKX_MUL_W-1:0]  LKX_MULT_RST = 32'd1103515245;
  localparam logic [LKX_WORD_W-1:0] LKX_INCR_RST = 31'd12345;
  localparam logic [LKX_WORD_W-1:0] LKX_MODU_RST = 31'd2147483647;
  localparam logic [LKX_WORD_W-1:0] LKX_SEED_RST = 31'd1;

  // word engine phases
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_MUL,
    ENG_REM,
    ENG_DONE
  } lkx_eng_phase_e;

  // recurrence coefficients seen by the engine
  typedef struct packed {
    logic [LKX_MUL_W-1:0]  mult;
    logic [LKX_WORD_W-1:0] incr;
    logic [LKX_WORD_W-1:0] modu;
  } lkx_lcg_cfg_t;

  // engine status towards the byte path
  typedef struct packed {
    logic                  done;
    logic [LKX_WORD_W-1:0] next_word;
  } lkx_eng_status_t;

endpackage

FILE: design/lkx_lcg_engine.sv
// ----------------------------------------------------------------------------
// lkx_lcg_engine: bit-serial next keystream word
// Forms multiplier * word + increment one multiplier bit a cycle in a 64-bit
// shift register, then reduces it modulo the modulus one bit a cycle.
// ----------------------------------------------------------------------------
module lkx_lcg_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lkx_pkg::lkx_lcg_cfg_t               cfg_i,
  input  logic                                kick_i,
  input  logic [lkx_pkg::LKX_WORD_W-1:0]      word_i,
  output lkx_pkg::lkx_eng_status_t            status_o
);
  import lkx_pkg::*;

  localparam int unsigned CntW = $clog2(LKX_PROD_W);
  localparam int unsigned HalfW = LKX_PROD_W / 2;
  localparam logic [CntW-1:0] MulLast = CntW'(LKX_MUL_W - 1);
  localparam logic [CntW-1:0] RemLast = CntW'(LKX_PROD_W - 1);

  lkx_eng_phase_e phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [HalfW-1:0] hi_q, lo_q;
  logic [LKX_WORD_W-1:0] w_q;
  logic [LKX_WORD_W-1:0] rem_q;

  logic [HalfW:0] mul_sum;
  logic [LKX_WORD_W:0] rem_s;
  logic [LKX_WORD_W+1:0] rem_diff;
  logic last_mul, last_rem;

  assign last_mul = (cnt_q == MulLast);
  assign last_rem = (cnt_q == RemLast);

  // shift-add step: add the word into the upper half when the multiplier bit is set
  assign mul_sum = {1'b0, hi_q} + (lo_q[0] ? {{(HalfW - LKX_WORD_W + 1){1'b0}}, w_q}
                                           : '0);

  // restoring step: bring in the next product bit, subtract the modulus if it fits
  // (a zero modulus keeps the low 31 bits, i.e. reduction modulo 2^31)
  assign rem_s    = {rem_q, hi_q[HalfW-1]};
  assign rem_diff = {1'b0, rem_s} - {2'b00, cfg_i.modu};

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (kick_i) begin
      phase_d = ENG_MUL;
    end else begin
      unique case (phase_q)
        ENG_MUL: if (last_mul) phase_d = ENG_REM;
        ENG_REM: if (last_rem) phase_d = ENG_DONE;
        ENG_IDLE, ENG_DONE: phase_d = phase_q;
        default: phase_d = ENG_IDLE;
      endcase
    end
  end

  // step counter
  always_comb begin
    cnt_d = cnt_q;
    if (kick_i) begin
      cnt_d = '0;
    end else if (phase_q == ENG_MUL) begin
      cnt_d = last_mul ? '0 : cnt_q + 1'b1;
    end else if (phase_q == ENG_REM) begin
      cnt_d = last_rem ? '0 : cnt_q + 1'b1;
    end
  end

  // status outputs
  always_comb begin
    status_o.done      = (phase_q == ENG_DONE);
    status_o.next_word = rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ENG_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // product and remainder shift registers
  always_ff @(posedge clk_i) begin
    if (kick_i) begin
      // increment preloaded in the upper half lands as a plain addend
      hi_q  <= {{(HalfW - LKX_WORD_W){1'b0}}, cfg_i.incr};
      lo_q  <= cfg_i.mult;
      w_q   <= word_i;
      rem_q <= '0;
    end else if (phase_q == ENG_MUL) begin
      hi_q <= mul_sum[HalfW:1];
      lo_q <= {mul_sum[0], lo_q[HalfW-1:1]};
    end else if (phase_q == ENG_REM) begin
      hi_q  <= {hi_q[HalfW-2:0], lo_q[HalfW-1]};
      lo_q  <= {lo_q[HalfW-2:0], 1'b0};
      rem_q <= rem_diff[LKX_WORD_W+1] ? rem_s[LKX_WORD_W-1:0]
                                      : rem_diff[LKX_WORD_W-1:0];
    end
  end

endmodule

FILE: design/lcg_keystream_xor_cipher_core.sv
// ----------------------------------------------------------------------------
// lcg_keystream_xor_cipher_core: lcg keystream xor cipher
// Xors each message byte with the next keystream byte; the following word
// is worked out bit-serially in the background while the current one is used.
// ----------------------------------------------------------------------------
// output: an accepted byte beat is registered, showing in the cycle after
// throughput: bytes 0 to 2 of a word one per cycle unless the output stalls;
//   byte 3 waits until the word engine has multiplied and reduced the next
//   word, so a long message is paced by the engine
// the engine restarts on a new word, a restart beat and every register write
// reset: registers take their reset values, key word 0 at byte 0, engine starts
module lcg_keystream_xor_cipher_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lkx_pkg::LKX_CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lkx_pkg::LKX_CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lkx_pkg::LKX_MSG_W-1:0]       msg_byte_i,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lkx_pkg::LKX_MSG_W-1:0]       cipher_byte_o
);
  import lkx_pkg::*;

  localparam logic [1:0] LastPos = 2'd3;

  lkx_lcg_cfg_t cfg_q;
  logic [LKX_WORD_W-1:0] seed_q;
  logic [LKX_WORD_W-1:0] key_word_q, key_word_d;
  logic [1:0] byte_pos_q, byte_pos_d;
  logic out_valid_q, out_valid_d;
  logic [LKX_MSG_W-1:0] cipher_q, cipher_d;
  logic init_q, cfg_kick_q;

  logic cfg_fire, in_fire, advance, kick;
  logic [LKX_WORD_W-1:0] cur_word;
  logic [1:0] cur_pos;
  logic [LKX_MSG_W-1:0] key_byte;
  lkx_eng_status_t eng_st;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  // take a byte when the output slot frees and its key word is known
  // (a finished word is stale in the cycle the engine restarts after a write)
  assign in_ready_o = (!out_valid_q || out_ready_i) &&
                      (restart_i || (byte_pos_q != LastPos) ||
                       (eng_st.done && !cfg_kick_q));
  assign in_fire    = in_valid_i & in_ready_o;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mult <= LKX_MULT_RST;
      cfg_q.incr <= LKX_INCR_RST;
      cfg_q.modu <= LKX_MODU_RST;
      seed_q     <= LKX_SEED_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        LKX_REG_MULT: cfg_q.mult <= cfg_data_i;
        LKX_REG_INCR: cfg_q.incr <= cfg_data_i[LKX_WORD_W-1:0];
        LKX_REG_MODU: cfg_q.modu <= cfg_data_i[LKX_WORD_W-1:0];
        LKX_REG_SEED: seed_q     <= cfg_data_i[LKX_WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // word and position in use for this beat
  assign cur_word = restart_i ? seed_q : key_word_q;
  assign cur_pos  = restart_i ? 2'd0 : byte_pos_q;

  always_comb begin
    unique case (cur_pos)
      2'd0: key_byte = cur_word[7:0];
      2'd1: key_byte = cur_word[15:8];
      2'd2: key_byte = cur_word[23:16];
      2'd3: key_byte = {1'b0, cur_word[30:24]};
      default: key_byte = '0;
    endcase
  end

  // keystream state
  assign advance = in_fire && (cur_pos == LastPos);

  always_comb begin
    key_word_d = key_word_q;
    byte_pos_d = byte_pos_q;
    if (in_fire) begin
      byte_pos_d = cur_pos + 2'd1;
      key_word_d = advance ? eng_st.next_word : cur_word;
    end
  end

  // engine restarts on a new word, a restart beat, after a write and after reset
  assign kick = init_q | cfg_kick_q | (in_fire && (restart_i || advance));

  // output register
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    cipher_d    = cipher_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      cipher_d    = msg_byte_i ^ key_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_word_q  <= '0;
      byte_pos_q  <= '0;
      out_valid_q <= 1'b0;
      init_q      <= 1'b1;
      cfg_kick_q  <= 1'b0;
    end else begin
      key_word_q  <= key_word_d;
      byte_pos_q  <= byte_pos_d;
      out_valid_q <= out_valid_d;
      init_q      <= 1'b0;
      cfg_kick_q  <= cfg_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    cipher_q <= cipher_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = cipher_q;

  lkx_lcg_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .kick_i   (kick),
    .word_i   (key_word_d),
    .status_o (eng_st)
  );

`ifndef SYNTHESIS
  // a word change only ever takes a finished engine result
  a_advance_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !restart_i && byte_pos_q == LastPos) |-> eng_st.done)
    else $error("keystream advanced before the next word was ready");

  // a finished word is reduced below a nonzero modulus
  a_word_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eng_st.done && !cfg_kick_q && cfg_q.modu != '0) |->
      (eng_st.next_word < cfg_q.modu))
    else $error("next keystream word not below modulus");

  // a restart beat leaves the keystream at byte 1 of the seed
  a_restart_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && restart_i) |=> (byte_pos_q == 2'd1 && key_word_q == $past(seed_q)))
    else $error("restart did not reload the seed");

  // every accepted beat yields an output beat
  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted beat gave no output");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the lcg keystream xor cipher core
// Sends message bytes and register writes over valid/ready channels, keeps
// its own keystream predictor and compares every output beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lkx_pkg::*;

  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RST_CYCLES    = 7;
  // let the word engine finish, with margin, before a register write
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned WDOG_LIMIT    = 4000;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned RANDOM_BYTES  = 1926;

  // indexes with no register behind them
  localparam logic [LKX_CFG_IDX_W-1:0] REG_SPARE_LO = 8'd4;
  localparam logic [LKX_CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [LKX_CFG_IDX_W-1:0]  cfg_index_i;
  logic [LKX_CFG_DATA_W-1:0] cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [LKX_MSG_W-1:0]      msg_byte_i;
  logic                      restart_i;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [LKX_MSG_W-1:0]      cipher_byte_o;

  // predictor copy of registers and keystream state
  logic [LKX_MUL_W-1:0]  lcg_mult;
  logic [LKX_WORD_W-1:0] lcg_incr;
  logic [LKX_WORD_W-1:0] lcg_modu;
  logic [LKX_WORD_W-1:0] lcg_seed;
  logic [LKX_WORD_W-1:0] ks_word;
  logic [1:0]            ks_pos;

  logic [LKX_MSG_W-1:0] cipher_exp_q[$];
  logic [LKX_MSG_W-1:0] cipher_want;

  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned rx_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_bytes = 0;
  int unsigned n_restarts = 0;
  int unsigned n_reg_writes = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;

  lcg_keystream_xor_cipher_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .msg_byte_i    (msg_byte_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cipher_byte_o (cipher_byte_o)
  );

  // clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // one step of the recurrence, 64-bit product, modulus zero keeps 31 bits
  function automatic logic [LKX_WORD_W-1:0] lcg_next_word(input logic [LKX_WORD_W-1:0] w);
    logic [LKX_PROD_W-1:0] mul_a;
    logic [LKX_PROD_W-1:0] mul_b;
    logic [LKX_PROD_W-1:0] acc;
    logic [LKX_PROD_W-1:0] rem;
    mul_a = {32'd0, lcg_mult};
    mul_b = {33'd0, w};
    acc   = mul_a * mul_b + {33'd0, lcg_incr};
    if (lcg_modu == '0) begin
      return acc[LKX_WORD_W-1:0];
    end
    rem = acc % {33'd0, lcg_modu};
    return rem[LKX_WORD_W-1:0];
  endfunction

  task automatic keystream_step(input logic [LKX_MSG_W-1:0] msg, input logic rs,
                                output logic [LKX_MSG_W-1:0] cb);
    logic [31:0] wide;
    if (rs) begin
      ks_word = lcg_seed;
      ks_pos  = 2'd0;
    end
    wide   = {1'b0, ks_word};
    cb     = msg ^ wide[8*ks_pos +: 8];
    ks_pos = ks_pos + 2'd1;
    if (ks_pos == 2'd0) begin
      ks_word = lcg_next_word(ks_word);
    end
  endtask

  // register write as seen by the predictor, bits above the width dropped
  task automatic reg_model_write(input logic [LKX_CFG_IDX_W-1:0] idx,
                                 input logic [LKX_CFG_DATA_W-1:0] data);
    case (idx)
      LKX_REG_MULT: lcg_mult = data;
      LKX_REG_INCR: lcg_incr = data[LKX_WORD_W-1:0];
      LKX_REG_MODU: lcg_modu = data[LKX_WORD_W-1:0];
      LKX_REG_SEED: lcg_seed = data[LKX_WORD_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- drivers

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit en);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!en || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // leaves valid high; the caller either sends the next beat or lowers it
  task automatic send_byte(input logic [LKX_MSG_W-1:0] msg, input logic rs);
    int unsigned          gap;
    logic [LKX_MSG_W-1:0] cb;
    gap = pick_gap(tx_idle_en);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    msg_byte_i <= msg;
    restart_i  <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    keystream_step(msg, rs, cb);
    cipher_exp_q = {cipher_exp_q, cb};
    n_bytes++;
    if (rs) begin
      n_restarts++;
    end
  endtask

  task automatic write_reg(input logic [LKX_CFG_IDX_W-1:0] idx,
                           input logic [LKX_CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_model_write(idx, data);
    n_reg_writes++;
  endtask

  task automatic load_regs(input logic [31:0] mult, input logic [31:0] incr,
                           input logic [31:0] modu, input logic [31:0] seed);
    write_reg(LKX_REG_MULT, mult);
    write_reg(LKX_REG_INCR, incr);
    write_reg(LKX_REG_MODU, modu);
    write_reg(LKX_REG_SEED, seed);
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending, wait for every result, then let the word engine finish
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (cipher_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold     <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
      rx_hold     <= pick_gap(1'b1);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checking

  // compare each output beat with the oldest expected byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_exp_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected cipher byte, expected none, actual %02h",
                 $time, cipher_byte_o);
      end else begin
        cipher_want = cipher_exp_q.pop_front();
        n_checked++;
        if (cipher_byte_o !== cipher_want) begin
          n_errors++;
          $display("%0t: cipher byte mismatch, expected %02h, actual %02h",
                   $time, cipher_want, cipher_byte_o);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < WDOG_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("%0t: watchdog, no beat for %0d cycles, %0d results outstanding",
               $time, WDOG_LIMIT, cipher_exp_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // no restart since reset: keystream runs from word zero
  task automatic test_unseeded_start();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // restart with the reset register values
  task automatic test_reset_registers();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b0);
  endtask

  // spare indexes ignored, upper bits dropped, seed equal to modulus
  task automatic test_register_edges();
    drain_and_settle();
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h0000_0000);
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // modulus zero after masking: reduction keeps 31 bits
  task automatic test_zero_modulus();
    drain_and_settle();
    load_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, $urandom());
    send_byte(8'h12, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  // seed well above a small modulus is used unreduced as first word
  task automatic test_seed_over_modulus();
    drain_and_settle();
    load_regs(LKX_MULT_RST, 32'd3, 32'd97, 32'h7FFF_FF00);
    send_byte(8'hC3, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
  endtask

  function automatic logic [31:0] pick_mult();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return LKX_MULT_RST;
      default: return $urandom();
    endcase
  endfunction

  // increment and seed data, top bit set at times to be dropped
  function automatic logic [31:0] pick_word_data();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(0, 1000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_modulus_data();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'h8000_0000;
      2:       return 32'd1;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(2, 300);
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned pick_msg_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 16);
    end
    if (r < 95) begin
      return $urandom_range(17, 64);
    end
    return $urandom_range(65, 200);
  endfunction

  // mostly well formed messages; a few carry on without restart or restart midway
  task automatic send_message(input int unsigned len);
    bit fresh;
    fresh = ($urandom_range(0, 9) != 0);
    for (int unsigned k = 0; k < len; k++) begin
      send_byte(8'($urandom_range(0, 255)),
                (k == 0) ? fresh : ($urandom_range(0, 149) == 0));
    end
  endtask

  // phases of random messages, each under fresh registers and idling mode
  task automatic test_random_messages();
    int unsigned quota;
    int unsigned sent;
    int unsigned len;
    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      drain_and_settle();
      tx_idle_en = (p != 0) && (p != 1);
      rx_idle_en = (p != 0) && (p != 2);
      load_regs(pick_mult(), pick_word_data(), pick_modulus_data(), pick_word_data());
      quota = RANDOM_BYTES / RAND_PHASES;
      sent  = 0;
      while (sent < quota) begin
        len = pick_msg_len();
        if (len > quota - sent) begin
          len = quota - sent;
        end
        send_message(len);
        sent += len;
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    msg_byte_i  <= '0;
    restart_i   <= 1'b0;
    lcg_mult = LKX_MULT_RST;
    lcg_incr = LKX_INCR_RST;
    lcg_modu = LKX_MODU_RST;
    lcg_seed = LKX_SEED_RST;
    ks_word  = '0;
    ks_pos   = 2'd0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unseeded_start();
    test_reset_registers();
    test_register_edges();
    test_zero_modulus();
    test_seed_over_modulus();
    test_random_messages();
    drain_and_settle();

    $display("covered %0d bytes with %0d restarts under %0d register writes,",
             n_bytes, n_restarts, n_reg_writes);
    $display("directed edge cases then %0d random phases; %0d beats checked, %0d bad",
             RAND_PHASES, n_checked, n_errors);
    if (n_errors == 0 && cipher_exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: lcg_keystream_xor_cipher_core.f
design/lkx_pkg.sv
design/lkx_lcg_engine.sv
design/lcg_keystream_xor_cipher_core.sv
verif/tb_top.sv
